FILE: rtl/srp_pkg.sv
// Shared types and constants for the SQL result row parser.
// No dependencies; srp_out_if and the parser refer to it by scoped names.
package srp_pkg;

    localparam int unsigned COL_INDEX_W = 15;
    localparam int unsigned ROW_INDEX_W = 24;

    localparam logic [7:0] TYPE_ROW_DESC = 8'h54;  // 'T'
    localparam logic [7:0] TYPE_DATA_ROW = 8'h44;  // 'D'
    localparam logic [4:0] ATTR_SKIP     = 5'd18;  // attribute bytes after each name

    typedef enum logic [3:0] {
        PH_EXPECT_T = 4'd0,
        PH_T_LEN    = 4'd1,
        PH_T_CNT    = 4'd2,
        PH_T_NAME   = 4'd3,
        PH_T_SKIP   = 4'd4,
        PH_EXPECT_D = 4'd5,
        PH_D_LEN    = 4'd6,
        PH_D_CNT    = 4'd7,
        PH_V_LEN    = 4'd8,
        PH_V_DATA   = 4'd9,
        PH_ERROR    = 4'd10,
        PH_DONE     = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FRAMING = 3'd0,
        KIND_NAME    = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

endpackage

FILE: rtl/srp_in_if.sv
// Input byte channel of the SQL result row parser.
// Depends on nothing.
interface srp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

FILE: rtl/srp_out_if.sv
// Tagged byte channel of the SQL result row parser.
// Depends on srp_pkg for the kind type and index widths.
interface srp_out_if;
    logic                              valid;
    logic                              ready;
    logic [7:0]                        byte_value;
    srp_pkg::kind_t                    byte_kind;
    logic [srp_pkg::COL_INDEX_W-1:0]   column_index;
    logic [srp_pkg::ROW_INDEX_W-1:0]   row_index;
    logic                              item_end;
    logic                              value_null;
    logic                              message_end;

    modport source (output valid, output byte_value, output byte_kind, output column_index,
                    output row_index, output item_end, output value_null,
                    output message_end, input ready);
    modport sink   (input valid, input byte_value, input byte_kind, input column_index,
                    input row_index, input item_end, input value_null,
                    input message_end, output ready);
endinterface

FILE: rtl/srp_cfg_if.sv
// Configuration write channel of the SQL result row parser (one 1-bit register).
// Depends on nothing.
interface srp_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sql_result_row_parser.sv
// SQL result row parser: tags every byte of a query response stream.
// Depends on srp_pkg, srp_in_if, srp_out_if and srp_cfg_if.
//
// Usage
//   rx  : one response byte per item, with restart marking the first type
//         byte of a new response (all parse state is cleared first).
//   tx  : one tagged item per input byte: the byte, its kind (framing, name,
//         value, error, finished), column and row indexes and end markers.
//   cfg : single-bit write of zero_length_is_null (reset 1); always ready.
//         Write only while the parser is idle.
// Timing
//   An item accepted on rx shows on tx in the cycle after. One byte per
//   cycle while tx keeps taking items: the whole per-byte decode sits
//   between the parse state registers and the tx output register.
// Reset
//   rst_n clears the parse state to "expect row description" and empties
//   the output register; the configuration bit returns to 1.
// Stalls
//   While tx holds an item that is not taken, rx.ready drops; a new byte is
//   taken in the same cycle the held item leaves.
module sql_result_row_parser #(
    parameter int unsigned ROW_INDEX_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    srp_in_if.sink      rx,
    srp_out_if.source   tx,
    srp_cfg_if.sink     cfg
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    srp_pkg::phase_t             phase_reg, phase_next;
    logic [2:0]                  hdr_reg, hdr_next;
    logic [15:0]                 ftotal_reg, ftotal_next;
    logic [15:0]                 fpos_reg, fpos_next;
    logic [31:0]                 vleft_reg, vleft_next;
    logic [4:0]                  skip_reg, skip_next;
    logic [ROW_INDEX_BITS-1:0]   row_reg, row_next;
    logic                        zlin_reg;

    logic                        out_valid_reg;
    logic [7:0]                  out_byte_reg;
    srp_pkg::kind_t              out_kind_reg, kind_next;
    logic [srp_pkg::COL_INDEX_W-1:0] out_col_reg, col_next;
    logic [srp_pkg::ROW_INDEX_W-1:0] out_row_reg;
    logic                        out_iend_reg, iend_next;
    logic                        out_vnull_reg, vnull_next;
    logic                        out_mend_reg, mend_next;

    logic                        in_acc;

    // state as seen by this byte: a restart clears it first
    srp_pkg::phase_t             eff_phase;
    logic [2:0]                  eff_hdr;
    logic [15:0]                 eff_ftotal;
    logic [15:0]                 eff_fpos;
    logic [31:0]                 eff_vleft;
    logic [4:0]                  eff_skip;
    logic [ROW_INDEX_BITS-1:0]   eff_row;

    logic [2:0]                  hdr_inc;
    logic [15:0]                 fpos_inc;
    logic                        last_item;
    logic                        row_can_inc;
    logic [ROW_INDEX_BITS-1:0]   row_inc;
    logic [15:0]                 ftotal_shift;
    logic [31:0]                 vleft_shift;
    logic [31:0]                 vleft_dec;
    logic [4:0]                  skip_dec;
    logic [7:0]                  b;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign rx.ready  = !out_valid_reg || tx.ready;
    assign in_acc    = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // ---------------------------------------------------------------
    // Per-byte decode
    // ---------------------------------------------------------------
    always_comb
    begin
        b          = rx.data_byte;
        eff_phase  = rx.restart ? srp_pkg::PH_EXPECT_T : phase_reg;
        eff_hdr    = rx.restart ? 3'd0  : hdr_reg;
        eff_ftotal = rx.restart ? 16'd0 : ftotal_reg;
        eff_fpos   = rx.restart ? 16'd0 : fpos_reg;
        eff_vleft  = rx.restart ? 32'd0 : vleft_reg;
        eff_skip   = rx.restart ? 5'd0  : skip_reg;
        eff_row    = rx.restart ? '0    : row_reg;

        hdr_inc      = eff_hdr + 3'd1;
        fpos_inc     = eff_fpos + 16'd1;
        last_item    = (fpos_inc >= eff_ftotal);
        row_can_inc  = (eff_row != {ROW_INDEX_BITS{1'b1}});
        row_inc      = row_can_inc ? eff_row + 1'b1 : eff_row;
        ftotal_shift = {eff_ftotal[7:0], b};
        vleft_shift  = {eff_vleft[23:0], b};
        vleft_dec    = (eff_vleft != 32'd0) ? eff_vleft - 32'd1 : eff_vleft;
        skip_dec     = (eff_skip != 5'd0) ? eff_skip - 5'd1 : eff_skip;

        phase_next  = eff_phase;
        hdr_next    = eff_hdr;
        ftotal_next = eff_ftotal;
        fpos_next   = eff_fpos;
        vleft_next  = eff_vleft;
        skip_next   = eff_skip;
        row_next    = eff_row;

        kind_next  = srp_pkg::KIND_FRAMING;
        iend_next  = 1'b0;
        vnull_next = 1'b0;
        mend_next  = 1'b0;

        unique case (eff_phase)
            srp_pkg::PH_EXPECT_T:
            begin
                if (b == srp_pkg::TYPE_ROW_DESC)
                begin
                    hdr_next   = 3'd0;
                    phase_next = srp_pkg::PH_T_LEN;
                end
                else
                begin
                    kind_next  = srp_pkg::KIND_ERROR;
                    phase_next = srp_pkg::PH_ERROR;
                end
            end
            srp_pkg::PH_T_LEN, srp_pkg::PH_D_LEN:
            begin
                hdr_next = hdr_inc;
                if (hdr_inc >= 3'd4)
                begin
                    hdr_next    = 3'd0;
                    ftotal_next = 16'd0;
                    phase_next  = (eff_phase == srp_pkg::PH_T_LEN) ? srp_pkg::PH_T_CNT
                                                                   : srp_pkg::PH_D_CNT;
                end
            end
            srp_pkg::PH_T_CNT, srp_pkg::PH_D_CNT:
            begin
                ftotal_next = ftotal_shift;
                hdr_next    = hdr_inc;
                if (hdr_inc >= 3'd2)
                begin
                    hdr_next   = 3'd0;
                    fpos_next  = 16'd0;
                    vleft_next = 32'd0;
                    if (ftotal_shift == 16'd0 || ftotal_shift[15])
                    begin
                        // empty or negative count: message ends here
                        ftotal_next = 16'd0;
                        mend_next   = 1'b1;
                        phase_next  = srp_pkg::PH_EXPECT_D;
                        if (eff_phase == srp_pkg::PH_D_CNT)
                            row_next = row_inc;
                    end
                    else
                    begin
                        phase_next = (eff_phase == srp_pkg::PH_T_CNT) ? srp_pkg::PH_T_NAME
                                                                      : srp_pkg::PH_V_LEN;
                    end
                end
            end
            srp_pkg::PH_T_NAME:
            begin
                if (b == 8'd0)
                begin
                    iend_next  = 1'b1;
                    skip_next  = srp_pkg::ATTR_SKIP;
                    phase_next = srp_pkg::PH_T_SKIP;
                end
                else
                begin
                    kind_next = srp_pkg::KIND_NAME;
                end
            end
            srp_pkg::PH_T_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 5'd0)
                begin
                    if (last_item)
                    begin
                        fpos_next   = 16'd0;
                        ftotal_next = 16'd0;
                        mend_next   = 1'b1;
                        phase_next  = srp_pkg::PH_EXPECT_D;
                    end
                    else
                    begin
                        fpos_next  = fpos_inc;
                        phase_next = srp_pkg::PH_T_NAME;
                    end
                end
            end
            srp_pkg::PH_EXPECT_D:
            begin
                if (b == srp_pkg::TYPE_DATA_ROW)
                begin
                    hdr_next   = 3'd0;
                    phase_next = srp_pkg::PH_D_LEN;
                end
                else
                begin
                    kind_next  = srp_pkg::KIND_DONE;
                    phase_next = srp_pkg::PH_DONE;
                end
            end
            srp_pkg::PH_V_LEN, srp_pkg::PH_V_DATA:
            begin
                if (eff_phase == srp_pkg::PH_V_LEN)
                begin
                    vleft_next = vleft_shift;
                    hdr_next   = hdr_inc;
                    if (hdr_inc >= 3'd4)
                    begin
                        hdr_next = 3'd0;
                        if (vleft_shift[31])
                        begin
                            iend_next  = 1'b1;
                            vnull_next = 1'b1;
                            vleft_next = 32'd0;
                        end
                        else if (vleft_shift == 32'd0)
                        begin
                            iend_next  = 1'b1;
                            vnull_next = zlin_reg;
                        end
                        else
                        begin
                            phase_next = srp_pkg::PH_V_DATA;
                        end
                    end
                end
                else
                begin
                    kind_next  = srp_pkg::KIND_VALUE;
                    vleft_next = vleft_dec;
                    if (vleft_dec == 32'd0)
                        iend_next = 1'b1;
                end
                // value closed: next column or end of row
                if (iend_next)
                begin
                    if (last_item)
                    begin
                        fpos_next   = 16'd0;
                        ftotal_next = 16'd0;
                        mend_next   = 1'b1;
                        phase_next  = srp_pkg::PH_EXPECT_D;
                        row_next    = row_inc;
                    end
                    else
                    begin
                        fpos_next  = fpos_inc;
                        phase_next = srp_pkg::PH_V_LEN;
                    end
                end
            end
            srp_pkg::PH_DONE:
            begin
                kind_next = srp_pkg::KIND_DONE;
            end
            default:
            begin
                kind_next  = srp_pkg::KIND_ERROR;
                phase_next = srp_pkg::PH_ERROR;
            end
        endcase

        // error and finished bytes carry column 0
        if (kind_next == srp_pkg::KIND_ERROR || kind_next == srp_pkg::KIND_DONE)
            col_next = '0;
        else
            col_next = eff_fpos[srp_pkg::COL_INDEX_W-1:0];
    end

    // ---------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= srp_pkg::PH_EXPECT_T;
            hdr_reg    <= 3'd0;
            ftotal_reg <= 16'd0;
            fpos_reg   <= 16'd0;
            vleft_reg  <= 32'd0;
            skip_reg   <= 5'd0;
            row_reg    <= '0;
        end
        else if (in_acc)
        begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            ftotal_reg <= ftotal_next;
            fpos_reg   <= fpos_next;
            vleft_reg  <= vleft_next;
            skip_reg   <= skip_next;
            row_reg    <= row_next;
        end
    end

    // configuration bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zlin_reg <= 1'b1;
        else if (cfg.valid && cfg.ready)
            zlin_reg <= cfg.data;
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rx.ready)
            out_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_byte_reg  <= b;
            out_kind_reg  <= kind_next;
            out_col_reg   <= col_next;
            out_row_reg   <= srp_pkg::ROW_INDEX_W'(eff_row);
            out_iend_reg  <= iend_next;
            out_vnull_reg <= vnull_next;
            out_mend_reg  <= mend_next;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.byte_value   = out_byte_reg;
    assign tx.byte_kind    = out_kind_reg;
    assign tx.column_index = out_col_reg;
    assign tx.row_index    = out_row_reg;
    assign tx.item_end     = out_iend_reg;
    assign tx.value_null   = out_vnull_reg;
    assign tx.message_end  = out_mend_reg;

`ifndef ASSERT_OFF
    // a message end always leaves the parser waiting for the next type byte
    a_mend_to_expect_d: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && mend_next) |=> (phase_reg == srp_pkg::PH_EXPECT_D))
        else $error("message end did not return to expect data row");

    // the attribute skip counter is never empty while skipping
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == srp_pkg::PH_T_SKIP) |-> (skip_reg != 5'd0))
        else $error("skip phase with empty counter");

    // row counter only grows between restarts
    a_row_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !rx.restart) |=> (row_reg >= $past(row_reg)))
        else $error("row counter went backwards");

    // null flag only on the last byte of an item
    a_null_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_vnull_reg) |-> out_iend_reg)
        else $error("value_null without item_end");

    // error and finished items carry column 0
    a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == srp_pkg::KIND_ERROR ||
                           out_kind_reg == srp_pkg::KIND_DONE)) |-> (out_col_reg == '0))
        else $error("non-zero column on error or finished item");
`endif

endmodule
